>>> rtl/vec4_normalize_macros.svh
// Assertion macros used by the vec4_normalize RTL.
`ifndef VEC4_NORMALIZE_MACROS_SVH
`define VEC4_NORMALIZE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define VN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vec4_normalize: check failed");

`define VN_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("vec4_normalize: check failed");

`else

`define VN_ASSERT(label, clk, rst, prop)
`define VN_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/vn_pkg.sv
// Constants shared by the vec4_normalize modules.
`timescale 1ns / 1ps
package vn_pkg;
   localparam int UNIT_FRAC_BITS = 14;
   localparam int UNIT_WIDTH     = 16;
   localparam int QUOT_BITS      = UNIT_FRAC_BITS + 1;
   localparam int LEN_WIDTH      = 17;
   localparam int LENSQ_WIDTH    = 33;
   localparam logic [63:0] LEN_MAX   = 64'h0000_0000_0001_FFFF;
   localparam logic [63:0] LENSQ_MAX = 64'h0000_0001_FFFF_FFFF;
endpackage

>>> rtl/vec4_normalize.sv
// Top level of vec4_normalize: squares, sum, square root chain, divider chain.
//
// Normalizes one signed Q8.8 four-component vector per clock cycle. There is
// one stage each for magnitude, squaring, pair sums, the saturated total and
// the output register, one cell per root bit in the square root chain (capped
// at 32 cells) and one cell per quotient bit in the divider chain. The whole
// pipeline advances together and holds only while a result sits unaccepted
// in the output register, so a new item is taken every cycle that the result
// side is not stalled.
`timescale 1ns / 1ps
`include "vec4_normalize_macros.svh"
module vec4_normalize import vn_pkg::*; #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [COMP_WIDTH-1:0] req_comp_z,
   input  logic signed [COMP_WIDTH-1:0] req_comp_w,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [UNIT_WIDTH-1:0] rsp_unit_x,
   output logic signed [UNIT_WIDTH-1:0] rsp_unit_y,
   output logic signed [UNIT_WIDTH-1:0] rsp_unit_z,
   output logic signed [UNIT_WIDTH-1:0] rsp_unit_w,
   output logic [LEN_WIDTH-1:0]         rsp_length,
   output logic [LENSQ_WIDTH-1:0]       rsp_length_squared,
   output logic                         rsp_zero_vector
);
   localparam int W    = COMP_WIDTH;
   localparam int SUMW = 2 * W + 2;
   localparam int SQW  = (SUMW > 64) ? 64 : SUMW;
   localparam int RW   = SQW / 2;
   localparam int QB   = QUOT_BITS;

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // magnitude stage
   logic [3:0][W-1:0] comp;
   logic [3:0][W-1:0] a_mag_ff, a_mag_in;
   logic [3:0]        a_neg_ff;
   logic              a_v_ff;

   assign comp = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_mag_in[i] = comp[i][W-1] ? W'(~comp[i] + 1'b1) : comp[i];
      end
   end

   // square stage
   logic [3:0][W-1:0]   b_mag_ff;
   logic [3:0]          b_neg_ff;
   logic [3:0][2*W-1:0] b_sq_ff;
   logic                b_v_ff;

   // pair sum stage
   logic [3:0][W-1:0] c_mag_ff;
   logic [3:0]        c_neg_ff;
   logic [1:0][2*W:0] c_p_ff;
   logic              c_v_ff;

   // total stage
   logic [3:0][W-1:0] d_mag_ff;
   logic [3:0]        d_neg_ff;
   logic [SQW-1:0]    d_sum_ff, d_sum_in;
   logic              d_v_ff;
   logic [SUMW-1:0]   total;

   assign total = SUMW'(c_p_ff[0]) + SUMW'(c_p_ff[1]);

   generate
      if (SUMW > 64) begin : g_sat
         assign d_sum_in = (|total[SUMW-1:64]) ? '1 : total[63:0];
      end else begin : g_nosat
         assign d_sum_in = total;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= a_mag_in;
         for (int i = 0; i < 4; i++) begin
            a_neg_ff[i] <= comp[i][W-1];
            b_sq_ff[i]  <= a_mag_ff[i] * a_mag_ff[i];
         end
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         c_mag_ff  <= b_mag_ff;
         c_neg_ff  <= b_neg_ff;
         c_p_ff[0] <= (2*W+1)'(b_sq_ff[0]) + (2*W+1)'(b_sq_ff[1]);
         c_p_ff[1] <= (2*W+1)'(b_sq_ff[2]) + (2*W+1)'(b_sq_ff[3]);
         d_mag_ff  <= c_mag_ff;
         d_neg_ff  <= c_neg_ff;
         d_sum_ff  <= d_sum_in;
      end
   end

   // square root chain
   logic [RW:0]                 s_v;
   logic [RW:0][SQW-1:0]        s_rad;
   logic [RW:0][RW-1:0]         s_root;
   logic [RW:0][RW+1:0]         s_rem;
   logic [RW:0][3:0][W-1:0]     s_mag;
   logic [RW:0][3:0]            s_neg;
   logic [RW:0][SQW-1:0]        s_sum;

   assign s_v[0]    = d_v_ff;
   assign s_rad[0]  = d_sum_ff;
   assign s_root[0] = '0;
   assign s_rem[0]  = '0;
   assign s_mag[0]  = d_mag_ff;
   assign s_neg[0]  = d_neg_ff;
   assign s_sum[0]  = d_sum_ff;

   generate
      for (genvar k = 0; k < RW; k++) begin : g_sqrt
         vn_sqrt_cell #(.SW(SQW), .RW(RW)) u_cell (
            .clock  (clock),
            .reset  (reset),
            .adv    (adv),
            .v_i    (s_v[k]),
            .rad_i  (s_rad[k]),
            .root_i (s_root[k]),
            .rem_i  (s_rem[k]),
            .v_o    (s_v[k+1]),
            .rad_o  (s_rad[k+1]),
            .root_o (s_root[k+1]),
            .rem_o  (s_rem[k+1])
         );

         always_ff @(posedge clock) begin
            if (adv) begin
               s_mag[k+1] <= s_mag[k];
               s_neg[k+1] <= s_neg[k];
               s_sum[k+1] <= s_sum[k];
            end
         end
      end
   endgenerate

   // divider chain
   logic [QB:0]                 q_v;
   logic [QB:0][RW-1:0]         q_len;
   logic [QB:0][3:0][RW-1:0]    q_rem;
   logic [QB:0][3:0][QB-1:0]    q_low;
   logic [QB:0][3:0][QB-1:0]    q_quo;
   logic [QB:0][3:0]            q_neg;
   logic [QB:0][SQW-1:0]        q_sum;

   assign q_v[0]   = s_v[RW];
   assign q_len[0] = s_root[RW];
   assign q_neg[0] = s_neg[RW];
   assign q_sum[0] = s_sum[RW];
   assign q_quo[0] = '0;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         q_rem[0][l] = RW'(s_mag[RW][l] >> 1);
         q_low[0][l] = {s_mag[RW][l][0], (QB-1)'(0)};
      end
   end

   generate
      for (genvar k = 0; k < QB; k++) begin : g_div
         vn_div_cell #(.RW(RW)) u_cell (
            .clock (clock),
            .reset (reset),
            .adv   (adv),
            .v_i   (q_v[k]),
            .len_i (q_len[k]),
            .rem_i (q_rem[k]),
            .low_i (q_low[k]),
            .q_i   (q_quo[k]),
            .v_o   (q_v[k+1]),
            .len_o (q_len[k+1]),
            .rem_o (q_rem[k+1]),
            .low_o (q_low[k+1]),
            .q_o   (q_quo[k+1])
         );

         always_ff @(posedge clock) begin
            if (adv) begin
               q_neg[k+1] <= q_neg[k];
               q_sum[k+1] <= q_sum[k];
            end
         end
      end
   endgenerate

   // output register
   logic                       zero_in;
   logic [3:0][UNIT_WIDTH-1:0] unit_in;
   logic [3:0][UNIT_WIDTH-1:0] unit_ff;
   logic [LEN_WIDTH-1:0]       len_in, len_ff;
   logic [LENSQ_WIDTH-1:0]     lsq_in, lsq_ff;
   logic                       zero_ff;
   logic [63:0]                len64;
   logic [63:0]                sum64;

   always_comb begin
      len64   = 64'(q_len[QB]);
      sum64   = 64'(q_sum[QB]);
      zero_in = q_len[QB] == '0;
      for (int l = 0; l < 4; l++) begin
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (q_neg[QB][l]) begin
            unit_in[l] = UNIT_WIDTH'(~{1'b0, q_quo[QB][l]} + 1'b1);
         end else begin
            unit_in[l] = UNIT_WIDTH'(q_quo[QB][l]);
         end
      end
      len_in = (len64 > LEN_MAX) ? '1 : len64[LEN_WIDTH-1:0];
      lsq_in = (sum64 > LENSQ_MAX) ? '1 : sum64[LENSQ_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_v[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         unit_ff <= unit_in;
         len_ff  <= len_in;
         lsq_ff  <= lsq_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unit_x         = unit_ff[0];
   assign rsp_unit_y         = unit_ff[1];
   assign rsp_unit_z         = unit_ff[2];
   assign rsp_unit_w         = unit_ff[3];
   assign rsp_length         = len_ff;
   assign rsp_length_squared = lsq_ff;
   assign rsp_zero_vector    = zero_ff;

   `VN_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)
   `VN_ASSERT(a_zero_fields, clock, reset, rsp_valid && rsp_zero_vector |-> rsp_length == '0 && rsp_length_squared == '0 && rsp_unit_x == '0 && rsp_unit_w == '0)
   `VN_ASSERT(a_nonzero_len, clock, reset, rsp_valid && !rsp_zero_vector |-> rsp_length != '0 && rsp_length_squared != '0)
   `VN_ASSERT(a_unit_range, clock, reset, rsp_valid |-> rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384)
endmodule

>>> rtl/vn_sqrt_cell.sv
// One digit cell of the square root chain: yields one root bit per stage.
`timescale 1ns / 1ps
module vn_sqrt_cell import vn_pkg::*; #(
   parameter int SW = 34,
   parameter int RW = SW / 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          v_i,
   input  logic [SW-1:0] rad_i,
   input  logic [RW-1:0] root_i,
   input  logic [RW+1:0] rem_i,
   output logic          v_o,
   output logic [SW-1:0] rad_o,
   output logic [RW-1:0] root_o,
   output logic [RW+1:0] rem_o
);
   logic [RW+3:0] rem_n;
   logic [RW+3:0] trial;
   logic          ge;
   logic          v_ff;
   logic [SW-1:0] rad_ff, rad_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW+1:0] rem_ff, rem_in;

   always_comb begin
      rem_n   = {rem_i, rad_i[SW-1:SW-2]};
      trial   = (RW+4)'({root_i, 2'b01});
      ge      = rem_n >= trial;
      rem_in  = ge ? (RW+2)'(rem_n - trial) : rem_n[RW+1:0];
      root_in = {root_i[RW-2:0], ge};
      rad_in  = {rad_i[SW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign v_o    = v_ff;
   assign rad_o  = rad_ff;
   assign root_o = root_ff;
   assign rem_o  = rem_ff;
endmodule

>>> rtl/vn_div_cell.sv
// One quotient-bit cell of the divider chain, four lanes sharing one divisor.
`timescale 1ns / 1ps
module vn_div_cell import vn_pkg::*; #(
   parameter int RW = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       v_i,
   input  logic [RW-1:0]              len_i,
   input  logic [3:0][RW-1:0]         rem_i,
   input  logic [3:0][QUOT_BITS-1:0]  low_i,
   input  logic [3:0][QUOT_BITS-1:0]  q_i,
   output logic                       v_o,
   output logic [RW-1:0]              len_o,
   output logic [3:0][RW-1:0]         rem_o,
   output logic [3:0][QUOT_BITS-1:0]  low_o,
   output logic [3:0][QUOT_BITS-1:0]  q_o
);
   logic                      v_ff;
   logic [RW-1:0]             len_ff;
   logic [3:0][RW-1:0]        rem_ff, rem_in;
   logic [3:0][QUOT_BITS-1:0] low_ff, low_in;
   logic [3:0][QUOT_BITS-1:0] q_ff, q_in;
   logic [3:0][RW:0]          t;
   logic [3:0]                ge;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         t[l]      = {rem_i[l], low_i[l][QUOT_BITS-1]};
         ge[l]     = t[l] >= {1'b0, len_i};
         rem_in[l] = ge[l] ? RW'(t[l] - {1'b0, len_i}) : t[l][RW-1:0];
         q_in[l]   = {q_i[l][QUOT_BITS-2:0], ge[l]};
         low_in[l] = {low_i[l][QUOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff <= len_i;
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
      end
   end

   assign v_o   = v_ff;
   assign len_o = len_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign q_o   = q_ff;
endmodule
